// ===== rtl/core/rrpc_pkg.sv =====
// shared types, codes and constants of the receive ring packet classifier
package rrpc_pkg;

	// default ring size in bytes, a power of two
	localparam int unsigned RING_BYTES = 8192;

	// reset value of our own ip address, 10.0.2.15
	localparam logic [31:0] OWN_IP_RESET = 32'h0A00_020F;

	// record queue between parser and output stage
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;
	localparam int unsigned QUEUE_CW    = 3;

	// offset of the next record is reported minus this amount
	localparam logic [15:0] CONSUMER_BIAS = 16'd16;

	// ethernet and protocol codes
	localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ARP_OP_REQ    = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
	localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
	localparam logic [7:0]  ICMP_ECHO_REPLY = 8'h00;
	localparam logic [7:0]  ICMP_NOT_SEEN = 8'hFF;
	localparam logic [3:0]  IP_MIN_IHL    = 4'd5;

	// result classes
	typedef enum logic [2:0] {
		ACT_STOP      = 3'd0,
		ACT_ARP_REPLY = 3'd1,
		ACT_ARP_REQ   = 3'd2,
		ACT_ECHO      = 3'd3,
		ACT_OTHER     = 3'd4
	} action_t;

	// one classified record handed from parser to output stage
	typedef struct packed {
		action_t     action;
		logic [31:0] peer_ip;
		logic [47:0] peer_mac;
		logic [15:0] frame_length;
	} rec_t;

endpackage

// ===== rtl/core/rrpc_front.sv =====
// byte parser and frame classifier of the receive ring packet classifier
module rrpc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         ring_byte,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               queue_full,
	output logic               rec_push,
	output rrpc_pkg::rec_t     rec
);

	logic [16:0] pos_q, pos_d;
	logic [16:0] last_q, last_d;
	logic        status0_q, status0_d;
	logic [15:0] len_q, len_d;
	logic [15:0] ftype_q, ftype_d;
	logic [15:0] arp_op_q, arp_op_d;
	logic [3:0]  ihl_q, ihl_d;
	logic [7:0]  proto_q, proto_d;
	logic [7:0]  icmp_q, icmp_d;
	logic [47:0] mac_q, mac_d;
	logic [31:0] sip_q, sip_d;
	logic [31:0] aip_q, aip_d;
	logic [31:0] own_ip_q;

	logic        acc;
	logic [16:0] f;
	logic        in_frame;
	logic [7:0]  icmp_off;
	logic [7:0]  icmp_off_d;
	logic        push_stop;
	logic        push_frame;
	logic        is_arp;
	logic        is_ipv4;

	assign byte_ready = !queue_full;
	assign acc        = byte_valid && byte_ready;
	assign f          = pos_q - 17'd4;
	assign in_frame   = (pos_q >= 17'd4) && (f < {1'b0, len_q});
	assign icmp_off   = 8'd14 + {2'b00, ihl_q, 2'b00};

	// next values of the parse state for the accepted byte
	always_comb begin
		pos_d     = pos_q;
		last_d    = last_q;
		status0_d = status0_q;
		len_d     = len_q;
		ftype_d   = ftype_q;
		arp_op_d  = arp_op_q;
		ihl_d     = ihl_q;
		proto_d   = proto_q;
		icmp_d    = icmp_q;
		mac_d     = mac_q;
		sip_d     = sip_q;
		aip_d     = aip_q;
		if (acc) begin
			if (pos_q == 17'd0) begin
				status0_d = ring_byte[0];
				ftype_d   = '0;
				arp_op_d  = '0;
				ihl_d     = '0;
				proto_d   = '0;
				icmp_d    = rrpc_pkg::ICMP_NOT_SEEN;
				mac_d     = '0;
				sip_d     = '0;
				aip_d     = '0;
			end else if (pos_q == 17'd2) begin
				len_d = {8'h00, ring_byte};
			end else if (pos_q == 17'd3) begin
				len_d  = {ring_byte, len_q[7:0]};
				// last byte position of the record: header, frame, rounding up to a four-byte boundary
				last_d = ({1'b0, len_d} + 17'd3) | 17'd3;
			end else if (in_frame) begin
				if (f == 17'd12) begin
					ftype_d = {ring_byte, 8'h00};
				end else if (f == 17'd13) begin
					ftype_d = {ftype_q[15:8], ring_byte};
				end else if (f >= 17'd14) begin
					if (ftype_q == rrpc_pkg::ETH_TYPE_ARP) begin
						if (f == 17'd20) begin
							arp_op_d = {ring_byte, 8'h00};
						end else if (f == 17'd21) begin
							arp_op_d = {arp_op_q[15:8], ring_byte};
						end else if (f >= 17'd22 && f <= 17'd27) begin
							mac_d = {mac_q[39:0], ring_byte};
						end else if (f >= 17'd28 && f <= 17'd31) begin
							sip_d = {sip_q[23:0], ring_byte};
						end else if (f >= 17'd38 && f <= 17'd41) begin
							aip_d = {aip_q[23:0], ring_byte};
						end
					end else if (ftype_q == rrpc_pkg::ETH_TYPE_IPV4) begin
						if (f == 17'd14) begin
							ihl_d = ring_byte[3:0];
						end else if (f == 17'd23) begin
							proto_d = ring_byte;
						end else if (f >= 17'd26 && f <= 17'd29) begin
							sip_d = {sip_q[23:0], ring_byte};
						end
						if (ihl_q >= rrpc_pkg::IP_MIN_IHL && f == {9'd0, icmp_off}) begin
							icmp_d = ring_byte;
						end
					end
				end
			end
		end
	end

	// record end detection
	assign push_stop  = acc && (pos_q == 17'd3) &&
	                    ((len_d == 16'd0) || !status0_q);
	assign push_frame = acc && (pos_q >= 17'd4) && (pos_q == last_q);
	assign rec_push   = push_stop || push_frame;

	// classification from the state including the final byte
	assign icmp_off_d = 8'd14 + {2'b00, ihl_d, 2'b00};
	assign is_arp     = (len_q >= 16'd14) && (ftype_d == rrpc_pkg::ETH_TYPE_ARP);
	assign is_ipv4    = (len_q >= 16'd14) && (ftype_d == rrpc_pkg::ETH_TYPE_IPV4);

	always_comb begin
		rec.action       = rrpc_pkg::ACT_OTHER;
		rec.peer_ip      = '0;
		rec.peer_mac     = '0;
		rec.frame_length = len_d;
		if (push_stop) begin
			rec.action = rrpc_pkg::ACT_STOP;
		end else if (is_arp) begin
			if (len_q >= 16'd32 && arp_op_d == rrpc_pkg::ARP_OP_REPLY) begin
				rec.action   = rrpc_pkg::ACT_ARP_REPLY;
				rec.peer_ip  = sip_d;
				rec.peer_mac = mac_d;
			end else if (len_q >= 16'd42 && arp_op_d == rrpc_pkg::ARP_OP_REQ &&
			             aip_d == own_ip_q) begin
				rec.action   = rrpc_pkg::ACT_ARP_REQ;
				rec.peer_ip  = sip_d;
				rec.peer_mac = mac_d;
			end
		end else if (is_ipv4) begin
			if (len_q >= 16'd30 && ihl_d >= rrpc_pkg::IP_MIN_IHL &&
			    proto_d == rrpc_pkg::IP_PROTO_ICMP &&
			    len_q > {8'h00, icmp_off_d} &&
			    icmp_d == rrpc_pkg::ICMP_ECHO_REPLY) begin
				rec.action  = rrpc_pkg::ACT_ECHO;
				rec.peer_ip = sip_d;
			end
		end
	end

	// control state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			own_ip_q <= rrpc_pkg::OWN_IP_RESET;
		end else begin
			if (cfg_wr_en) begin
				own_ip_q <= cfg_wr_data;
			end
			if (acc) begin
				pos_q <= rec_push ? 17'd0 : pos_q + 17'd1;
			end
		end
	end

	// frame fields, cleared at the first header byte of every record
	always_ff @(posedge clk) begin
		last_q    <= last_d;
		status0_q <= status0_d;
		len_q     <= len_d;
		ftype_q   <= ftype_d;
		arp_op_q  <= arp_op_d;
		ihl_q     <= ihl_d;
		proto_q   <= proto_d;
		icmp_q    <= icmp_d;
		mac_q     <= mac_d;
		sip_q     <= sip_d;
		aip_q     <= aip_d;
	end

endmodule

// ===== rtl/core/rrpc_queue.sv =====
// short record queue between parser and output stage
module rrpc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rrpc_pkg::rec_t push_rec,
	output logic           full,
	output logic           valid,
	input  logic           pop,
	output rrpc_pkg::rec_t head_rec
);

	logic [rrpc_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [rrpc_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [rrpc_pkg::QUEUE_CW-1:0] count_q;
	rrpc_pkg::rec_t                mem_q [rrpc_pkg::QUEUE_DEPTH];

	assign full     = count_q == rrpc_pkg::QUEUE_CW'(rrpc_pkg::QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign head_rec = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ===== rtl/core/rrpc_back.sv =====
// output stage: ring offset tracking and result register
module rrpc_back #(
	parameter int unsigned OFS_W = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	output logic               rec_pop,
	input  rrpc_pkg::rec_t     rec,
	output logic               out_valid,
	input  logic               out_ready,
	output rrpc_pkg::rec_t     out_rec,
	output logic [OFS_W-1:0]   out_next,
	output logic [15:0]        out_cp
);

	logic [OFS_W-1:0] rp_q;
	logic [OFS_W-1:0] sum;
	logic [OFS_W-1:0] next;
	logic             out_valid_q;
	rrpc_pkg::rec_t   out_rec_q;
	logic [OFS_W-1:0] out_next_q;
	logic [15:0]      out_cp_q;

	assign rec_pop = rec_valid && (!out_valid_q || out_ready);

	// next record offset, aligned and wrapped to the ring size
	assign sum  = rp_q + rec.frame_length[OFS_W-1:0] + OFS_W'(7);
	assign next = (rec.action == rrpc_pkg::ACT_STOP) ? rp_q : {sum[OFS_W-1:2], 2'b00};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_pop) begin
				rp_q        <= next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rec_pop) begin
			out_rec_q  <= rec;
			out_next_q <= next;
			out_cp_q   <= 16'(next) - rrpc_pkg::CONSUMER_BIAS;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;
	assign out_next  = out_next_q;
	assign out_cp    = out_cp_q;

endmodule

// ===== rtl/core/rx_ring_packet_classifier.sv =====
// top level of the receive ring packet classifier
//
// Takes receive ring bytes in ring order on s_axis, one byte per item, and
// gives one result item on m_axis per record: the class of the frame, the
// peer address, the frame length and the next read offsets. A record whose
// header has length zero or status bit 0 clear gives a stop result right
// after its fourth byte and the read offset stays where it was.
// Throughput: one byte per cycle, sustained as long as m_axis drains; a
// result costs at least four bytes, so the output side never limits it.
// The queue takes a record when its last byte is accepted, and the output
// register loads it from there once that register is free; m_axis_tvalid
// is driven by the output register.
// A four-entry record queue sits between the byte parser and the output
// register; s_axis_tready drops only when that queue is full, so a stalled
// receiver holds back input once four records wait behind the one held in
// the output register.
// Reset clears the parse position, the read offset, the queue and the
// output valid, and loads our ip address with 10.0.2.15. cfg_wr_en writes
// our ip address (big-endian); write it only while idle.
// RING_BYTES must be a power of two.
module rx_ring_packet_classifier #(
	parameter int unsigned RING_BYTES = rrpc_pkg::RING_BYTES,
	localparam int unsigned OFS_W = $clog2(RING_BYTES),
	localparam int unsigned TDATA_W = ((115 + OFS_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // ring_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// action, peer_ip, peer_mac, frame_length, next_read_offset, consumer_pointer
	output logic [TDATA_W-1:0] m_axis_tdata,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data
);

	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	logic           rec_push;
	rrpc_pkg::rec_t front_rec;
	rrpc_pkg::rec_t head_rec;
	rrpc_pkg::rec_t out_rec;
	logic [OFS_W-1:0] out_next;
	logic [15:0]    out_cp;

	// byte parser and classifier
	rrpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (s_axis_tvalid),
		.byte_ready  (s_axis_tready),
		.ring_byte   (s_axis_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.queue_full  (q_full),
		.rec_push    (rec_push),
		.rec         (front_rec)
	);

	// record queue
	rrpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_push),
		.push_rec (front_rec),
		.full     (q_full),
		.valid    (q_valid),
		.pop      (q_pop),
		.head_rec (head_rec)
	);

	// offset tracking and output register
	rrpc_back #(
		.OFS_W (OFS_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_valid),
		.rec_pop   (q_pop),
		.rec       (head_rec),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rec   (out_rec),
		.out_next  (out_next),
		.out_cp    (out_cp)
	);

	// result packing, first field in the lowest bits
	assign m_axis_tdata = TDATA_W'({out_cp, out_next, out_rec.frame_length,
	                                out_rec.peer_mac, out_rec.peer_ip, out_rec.action});

`ifndef SYNTHESIS
	// no record is pushed into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) !(rec_push && q_full))
		else $error("record pushed into full queue");

	// every reported offset is word aligned
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_next[1:0] == 2'b00))
		else $error("next read offset not aligned");

	// consumer pointer tracks the next offset
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_cp == 16'(out_next) - rrpc_pkg::CONSUMER_BIAS))
		else $error("consumer pointer mismatch");

	// peer fields are zero for stop and other results
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (out_rec.action == rrpc_pkg::ACT_STOP ||
		                   out_rec.action == rrpc_pkg::ACT_OTHER))
		|-> (out_rec.peer_ip == '0 && out_rec.peer_mac == '0))
		else $error("peer fields set on unclassified result");
`endif

endmodule
